/* hdl/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types, widths, register indexes and the sine table generator for the
// planar frame transform.
// ----------------------------------------------------------------------------
package pft_pkg;

  // Field widths
  localparam int COORD_W   = 32;
  localparam int HEADING_W = 16;
  localparam int TRIG_W    = 17;               // Q15, -1.0 .. +1.0
  localparam int ROM_W     = 16;               // 0 .. 32768
  localparam int FRAC_BITS = 15;

  // Datapath widths
  localparam int OP_W   = COORD_W + 1;         // difference of two coordinates
  localparam int PROD_W = OP_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W - FRAC_BITS;
  localparam int FIN_W  = RND_W + 1;           // rounded sum plus anchor

  localparam logic signed [COORD_W-1:0] OUT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] OUT_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [ROM_W-1:0]          Q15_ONE = ROM_W'(32768);

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_X      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_Y      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEADING = 2'd2;

  typedef struct packed {
    logic [TRIG_W-1:0] cos_q15;
    logic [TRIG_W-1:0] sin_q15;
  } pft_trig_t;

  typedef struct packed {
    logic                clip;
    logic [COORD_W-1:0]  value;
  } pft_sat_t;

  // pi/2 in Q30 and the Taylor divisors (2j)(2j+1)
  localparam longint unsigned PiHalfQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156};

  // Quarter-wave sine entry k of a 2^bits table, Q15. Evaluated at elaboration.
  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned kk;
    longint          sum;
    longint unsigned r;
    kk = longint'(k);
    if (kk > (64'd1 << bits)) kk = 64'd1 << bits;
    x    = (kk * PiHalfQ30) >> bits;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    for (int j = 0; j < 6; j++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = (term + TaylorDiv[j] / 2) / TaylorDiv[j];
      if (j % 2 == 0) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + (64'd1 << 14)) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return ROM_W'(r);
  endfunction

  // Clip a final coordinate to 32 bits
  function automatic pft_sat_t saturate(input logic signed [FIN_W-1:0] v);
    pft_sat_t res;
    if (v > FIN_W'(OUT_MAX)) begin
      res.clip  = 1'b1;
      res.value = OUT_MAX;
    end else if (v < FIN_W'(OUT_MIN)) begin
      res.clip  = 1'b1;
      res.value = OUT_MIN;
    end else begin
      res.clip  = 1'b0;
      res.value = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/pft_heading.sv */
// ----------------------------------------------------------------------------
// pft_heading
// Quarter-wave sine ROM and the held cosine/sine of the frame heading.
// ----------------------------------------------------------------------------
module pft_heading
  import pft_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  logic [HEADING_W-1:0] heading,
  output pft_trig_t            trig
);

  localparam int RomDepth = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W    = SINE_TABLE_BITS + 1;
  localparam int PHASE_W  = HEADING_W - 2;
  localparam int Shift    = PHASE_W - SINE_TABLE_BITS;

  logic [ROM_W-1:0] rom [RomDepth];

  for (genvar k = 0; k < RomDepth; k++) begin : g_rom
    assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  logic [PHASE_W:0]  phase_sum;
  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  idx_b;

  // nearest table entry for the phase within the quadrant
  assign phase_sum = {1'b0, heading[PHASE_W-1:0]} + (PHASE_W + 1)'(1 << (Shift - 1));
  assign idx_a     = phase_sum[PHASE_W:Shift];
  assign idx_b     = IDX_W'(RomDepth - 1) - idx_a;

  logic [ROM_W-1:0] rd_a;
  logic [ROM_W-1:0] rd_b;
  logic [1:0]       quad;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_a <= '0;
      rd_b <= Q15_ONE;
      quad <= 2'd0;
    end else if (wr) begin
      rd_a <= rom[idx_a];
      rd_b <= rom[idx_b];
      quad <= heading[HEADING_W-1:HEADING_W-2];
    end
  end

  logic signed [TRIG_W-1:0] pos_a;
  logic signed [TRIG_W-1:0] pos_b;

  assign pos_a = $signed({1'b0, rd_a});
  assign pos_b = $signed({1'b0, rd_b});

  always_comb begin
    case (quad)
      2'd0: begin
        trig.sin_q15 = pos_a;
        trig.cos_q15 = pos_b;
      end
      2'd1: begin
        trig.sin_q15 = pos_b;
        trig.cos_q15 = -pos_a;
      end
      2'd2: begin
        trig.sin_q15 = -pos_a;
        trig.cos_q15 = -pos_b;
      end
      default: begin
        trig.sin_q15 = -pos_b;
        trig.cos_q15 = pos_a;
      end
    endcase
  end

endmodule

/* hdl/planar_frame_transform_top.sv */
// ----------------------------------------------------------------------------
// planar_frame_transform_top
// Rotation/translation of a planar point between world and anchored frame.
// ----------------------------------------------------------------------------
// A point is taken each cycle in which start is high and busy is low. Its
// result is registered onto out_x/out_y/saturated, with done high for a
// single cycle alongside it. Results come back in issue order. The three
// register stages (operand, products, rounding and clipping) lie between
// acceptance and the result; throughput is one point per cycle. The result
// cannot be held off, so sample it when done is high. busy is high only
// during reset and the cycle after it. Writing the heading register looks up
// cosine and sine in the sine ROM at that edge, so a point may follow on the
// very next cycle; registers are to be written only while no point is in
// flight, which the block itself does not enforce.
module planar_frame_transform_top
  import pft_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic signed [COORD_W-1:0]   in_x,
  input  logic signed [COORD_W-1:0]   in_y,
  input  logic                        cfg_wr,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data,
  output logic                        done,
  output logic signed [COORD_W-1:0]   out_x,
  output logic signed [COORD_W-1:0]   out_y,
  output logic                        saturated
);

  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  pft_trig_t                 trig;
  logic                      accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      origin_x <= '0;
      origin_y <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_wr && cfg_index == REG_ANCHOR_X) origin_x <= $signed(cfg_data);
      if (cfg_wr && cfg_index == REG_ANCHOR_Y) origin_y <= $signed(cfg_data);
    end
  end

  pft_heading #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_heading (
    .clk    (clk),
    .rst    (rst),
    .wr     (cfg_wr && cfg_index == REG_FRAME_HEADING),
    .heading(cfg_data[HEADING_W-1:0]),
    .trig   (trig)
  );

  logic signed [TRIG_W-1:0] cos_s;
  logic signed [TRIG_W-1:0] sin_s;

  assign cos_s = $signed(trig.cos_q15);
  assign sin_s = $signed(trig.sin_q15);

  // stage 1: operands (world to relative subtracts the anchor first)
  logic                   v1;
  logic                   mode1;
  logic signed [OP_W-1:0] op_x;
  logic signed [OP_W-1:0] op_y;

  // stage 2: products
  logic                     v2;
  logic                     mode2;
  logic signed [PROD_W-1:0] p_xc;
  logic signed [PROD_W-1:0] p_ys;
  logic signed [PROD_W-1:0] p_xs;
  logic signed [PROD_W-1:0] p_yc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode1 <= mode;
      if (mode) begin
        op_x <= OP_W'(in_x);
        op_y <= OP_W'(in_y);
      end else begin
        op_x <= OP_W'(in_x) - OP_W'(origin_x);
        op_y <= OP_W'(in_y) - OP_W'(origin_y);
      end
    end
    if (v1) begin
      mode2 <= mode1;
      p_xc  <= op_x * cos_s;
      p_ys  <= op_y * sin_s;
      p_xs  <= op_x * sin_s;
      p_yc  <= op_y * cos_s;
    end
  end

  // stage 3: combine, round to nearest, add anchor back (relative to world), clip
  localparam logic signed [SUM_W-1:0] RoundHalf = SUM_W'(1 << (FRAC_BITS - 1));

  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] bias_x;
  logic signed [SUM_W-1:0] bias_y;
  logic signed [RND_W-1:0] rnd_x;
  logic signed [RND_W-1:0] rnd_y;
  logic signed [FIN_W-1:0] fin_x;
  logic signed [FIN_W-1:0] fin_y;
  pft_sat_t                sat_x;
  pft_sat_t                sat_y;

  always_comb begin
    if (mode2) begin
      sum_x = p_xc + p_ys;
      sum_y = p_yc - p_xs;
    end else begin
      sum_x = p_xc - p_ys;
      sum_y = p_xs + p_yc;
    end
    bias_x = sum_x + RoundHalf;
    bias_y = sum_y + RoundHalf;
    rnd_x  = bias_x[SUM_W-1:FRAC_BITS];
    rnd_y  = bias_y[SUM_W-1:FRAC_BITS];
    if (mode2) begin
      fin_x = FIN_W'(rnd_x) + FIN_W'(origin_x);
      fin_y = FIN_W'(rnd_y) + FIN_W'(origin_y);
    end else begin
      fin_x = FIN_W'(rnd_x);
      fin_y = FIN_W'(rnd_y);
    end
    sat_x = saturate(fin_x);
    sat_y = saturate(fin_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      out_x     <= $signed(sat_x.value);
      out_y     <= $signed(sat_y.value);
      saturated <= sat_x.clip || sat_y.clip;
    end
  end

endmodule

/* hdl/pft_checker.sv */
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks of the planar frame transform, bound to the top level.
// ----------------------------------------------------------------------------
module pft_checker
  import pft_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      mode,
  input logic signed [COORD_W-1:0] in_x,
  input logic signed [COORD_W-1:0] in_y,
  input logic                      done,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input logic                      saturated
);

  // every accepted transaction produces a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##2 done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching transaction");

  // a clipped result sits on a range limit
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> (out_x == OUT_MAX || out_x == OUT_MIN ||
                           out_y == OUT_MAX || out_y == OUT_MIN))
    else $error("saturated flag without a clipped coordinate");

  // origin of the anchored frame maps to the anchor itself, never clipped
  a_origin_no_clip: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode && in_x == '0 && in_y == '0 |=> ##2 !saturated)
    else $error("frame origin reported as saturated");

endmodule

bind planar_frame_transform_top pft_checker u_pft_checker (.*);

/* dv/tb_planar_frame_transform_top.sv */
// ----------------------------------------------------------------------------
// tb_planar_frame_transform_top
// Self-checking bench for the planar frame transform. Points stream in through
// start/busy with random gaps. A local fixed-point predictor (own quarter-wave
// sine, Q15 rounding, 32-bit clipping) computes each expected point, and every
// done transaction is compared field by field against the oldest expectation.
// Registers are rewritten between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_planar_frame_transform_top;
  import pft_pkg::*;

  localparam int          SINE_BITS   = 8;
  localparam int unsigned TABLE_N     = 1 << SINE_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int          CYCLE_LIMIT = 100000;
  localparam int          RAND_PHASES = 12;
  localparam int          PHASE_ITEMS = 96;

  localparam logic MODE_TO_FRAME = 1'b0;
  localparam logic MODE_TO_WORLD = 1'b1;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      clip;
  } frame_result_t;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      start     = 1'b0;
  logic                      busy;
  logic                      mode      = 1'b0;
  logic signed [COORD_W-1:0] in_x      = '0;
  logic signed [COORD_W-1:0] in_y      = '0;
  logic                      cfg_wr    = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data  = '0;
  logic                      done;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      saturated;

  planar_frame_transform_top #(.SINE_TABLE_BITS(SINE_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .in_x      (in_x),
    .in_y      (in_y),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .saturated (saturated)
  );

  // Predictor state
  logic signed [COORD_W-1:0] origin_x = '0;
  logic signed [COORD_W-1:0] origin_y = '0;
  logic signed [TRIG_W-1:0]  held_cos = TRIG_W'(32768);
  logic signed [TRIG_W-1:0]  held_sin = '0;

  point_req_t    pending_points[$];
  frame_result_t results_due[$];
  point_req_t    issue_item;
  frame_result_t want;
  logic          took = 1'b0;
  int            idle_pct = 31;
  int            points_queued = 0;
  int            results_matched = 0;
  int            errors = 0;
  int            cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Entry k of the quarter-wave sine, Q15, by Taylor series in Q30
  function automatic longint quarter_sine(input int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint          acc;
    longint          r;
    int unsigned     k;
    k    = (idx > TABLE_N) ? TABLE_N : idx;
    x    = (64'(k) * HALF_PI_Q30) >> SINE_BITS;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc  = longint'(x);
    for (int j = 1; j <= 6; j++) begin
      dv   = 64'((2 * j) * (2 * j + 1));
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = (term + dv / 2) / dv;
      if (j % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32768) r = 32768;
    return r;
  endfunction

  function automatic void set_heading(input logic [HEADING_W-1:0] h);
    int unsigned i;
    longint      a;
    longint      b;
    // nearest table entry within the quadrant
    i = (int'(h[13:0]) + (1 << (13 - SINE_BITS))) >> (14 - SINE_BITS);
    a = quarter_sine(i);
    b = quarter_sine(TABLE_N - i);
    case (h[15:14])
      2'd0: begin held_sin = TRIG_W'(a);  held_cos = TRIG_W'(b);  end
      2'd1: begin held_sin = TRIG_W'(b);  held_cos = TRIG_W'(-a); end
      2'd2: begin held_sin = TRIG_W'(-a); held_cos = TRIG_W'(-b); end
      default: begin held_sin = TRIG_W'(-b); held_cos = TRIG_W'(a); end
    endcase
  endfunction

  // floor((v + 2^14) / 2^15)
  function automatic longint q15_round(input longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic pft_sat_t clip32(input longint v);
    pft_sat_t r;
    r.clip  = 1'b1;
    if (v > longint'(OUT_MAX))      r.value = OUT_MAX;
    else if (v < longint'(OUT_MIN)) r.value = OUT_MIN;
    else begin
      r.clip  = 1'b0;
      r.value = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic frame_result_t frame_point(input logic m,
                                                input logic signed [COORD_W-1:0] px,
                                                input logic signed [COORD_W-1:0] py);
    frame_result_t r;
    pft_sat_t      cx;
    pft_sat_t      cy;
    longint        c;
    longint        s;
    longint        x;
    longint        y;
    longint        rx;
    longint        ry;
    c = longint'(held_cos);
    s = longint'(held_sin);
    x = longint'(px);
    y = longint'(py);
    if (m == MODE_TO_FRAME) begin
      x  = x - longint'(origin_x);
      y  = y - longint'(origin_y);
      rx = q15_round(x * c - y * s);
      ry = q15_round(x * s + y * c);
    end else begin
      // rotation is rounded before the anchor is added back
      rx = longint'(origin_x) + q15_round(x * c + y * s);
      ry = longint'(origin_y) + q15_round(y * c - x * s);
    end
    cx     = clip32(rx);
    cy     = clip32(ry);
    r.x    = cx.value;
    r.y    = cy.value;
    r.clip = cx.clip | cy.clip;
    return r;
  endfunction

  // Driver: new point after the previous transaction, random gaps
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
        issue_item = pending_points.pop_front();
        start <= 1'b1;
        mode  <= issue_item.mode;
        in_x  <= issue_item.x;
        in_y  <= issue_item.y;
      end else begin
        start <= 1'b0;
        mode  <= 1'($urandom);
        in_x  <= $urandom;
        in_y  <= $urandom;
      end
    end
  end

  // Monitor: predict on acceptance, check on done, track register writes
  always @(posedge clk) begin
    if (rst) begin
      took     <= 1'b0;
      origin_x = '0;
      origin_y = '0;
      set_heading('0);
    end else begin
      took <= start && !busy;
      if (start && !busy) results_due.push_back(frame_point(mode, in_x, in_y));
      if (cfg_wr) begin
        case (cfg_index)
          REG_ANCHOR_X:      origin_x = cfg_data;
          REG_ANCHOR_Y:      origin_y = cfg_data;
          REG_FRAME_HEADING: set_heading(cfg_data[HEADING_W-1:0]);
          default: ;
        endcase
      end
      if (done) begin
        if (results_due.size() == 0) begin
          $error("unexpected transaction: out_x %0d out_y %0d", out_x, out_y);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, out_x);
            errors++;
          end
          if (out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, out_y);
            errors++;
          end
          if (saturated !== want.clip) begin
            $error("saturated: expected %0b, got %0b", want.clip, saturated);
            errors++;
          end
          results_matched++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_point(input logic m, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
    point_req_t p;
    p.mode = m;
    p.x    = x;
    p.y    = y;
    pending_points.push_back(p);
    points_queued++;
  endtask

  // Hold off until every queued point has come back
  task automatic drain();
    do @(negedge clk); while (results_matched < points_queued);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [COORD_W-1:0] value);
    @(negedge clk);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr    <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return OUT_MIN;
      1:       return OUT_MAX;
      2:       return '0;
      3:       return '1;
      default: return 32'd1;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] centre);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return centre + $urandom_range(131072) - 32'd65536;
      default:       return pick_extreme();
    endcase
  endfunction

  function automatic logic [HEADING_W-1:0] pick_heading();
    case ($urandom_range(11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h4000;
      3:       return 16'h8000;
      4:       return 16'hC000;
      5:       return 16'h3FFF;
      6:       return 16'h2000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic               m;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (busy);

    // Reset settings: identity rotation, zero anchor
    queue_point(MODE_TO_FRAME, OUT_MIN, OUT_MAX);
    queue_point(MODE_TO_FRAME, OUT_MAX, OUT_MIN);
    queue_point(MODE_TO_FRAME, 32'd0, 32'd0);
    queue_point(MODE_TO_WORLD, 32'hFFFF_FFFF, 32'd1);
    queue_point(MODE_TO_WORLD, OUT_MIN, OUT_MIN);
    queue_point(MODE_TO_WORLD, OUT_MAX, OUT_MAX);
    drain();

    // Opposite anchor corners, 45 degrees with junk above the heading bits,
    // and a write to the unused index that must change nothing
    write_reg(REG_ANCHOR_X, OUT_MIN);
    write_reg(REG_ANCHOR_Y, OUT_MAX);
    write_reg(REG_FRAME_HEADING, 32'hA5A5_2000);
    write_reg(REG_SPARE, 32'h1234_5678);
    queue_point(MODE_TO_FRAME, OUT_MAX, OUT_MIN);
    queue_point(MODE_TO_FRAME, OUT_MIN, OUT_MAX);
    queue_point(MODE_TO_WORLD, OUT_MAX, OUT_MAX);
    queue_point(MODE_TO_WORLD, OUT_MIN, OUT_MIN);
    queue_point(MODE_TO_WORLD, 32'd0, 32'd0);
    queue_point(MODE_TO_FRAME, 32'd1, 32'hFFFF_FFFF);
    queue_point(MODE_TO_WORLD, OUT_MIN, OUT_MAX);
    drain();

    write_reg(REG_ANCHOR_X, OUT_MAX);
    write_reg(REG_ANCHOR_Y, OUT_MIN);
    write_reg(REG_FRAME_HEADING, 32'h0000_FFFF);
    queue_point(MODE_TO_WORLD, OUT_MAX, OUT_MIN);
    queue_point(MODE_TO_WORLD, OUT_MIN, OUT_MAX);
    queue_point(MODE_TO_FRAME, OUT_MIN, OUT_MAX);
    queue_point(MODE_TO_FRAME, OUT_MAX, OUT_MIN);
    queue_point(MODE_TO_FRAME, 32'd256, 32'hFFFF_FF00);
    drain();

    // Half turn: negating the most negative coordinate overflows
    write_reg(REG_ANCHOR_X, 32'd0);
    write_reg(REG_ANCHOR_Y, 32'd0);
    write_reg(REG_FRAME_HEADING, 32'h0000_8000);
    queue_point(MODE_TO_FRAME, OUT_MIN, OUT_MIN);
    queue_point(MODE_TO_WORLD, OUT_MIN, 32'd0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // one phase runs back to back with no gaps
      idle_pct = (ph == 5) ? 0 : 31;
      case ($urandom_range(5))
        0:       ax = OUT_MIN;
        1:       ax = OUT_MAX;
        2:       ax = '0;
        3:       ax = $urandom_range(131072) - 32'd65536;
        default: ax = $urandom;
      endcase
      case ($urandom_range(5))
        0:       ay = OUT_MIN;
        1:       ay = OUT_MAX;
        2:       ay = '0;
        3:       ay = $urandom_range(131072) - 32'd65536;
        default: ay = $urandom;
      endcase
      write_reg(REG_ANCHOR_X, ax);
      write_reg(REG_ANCHOR_Y, ay);
      write_reg(REG_FRAME_HEADING, {16'($urandom), pick_heading()});
      if ($urandom_range(2) == 0) write_reg(REG_SPARE, $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        m = 1'($urandom_range(1));
        // relative points sit near the origin, world points near the anchor
        if (m == MODE_TO_FRAME) queue_point(m, pick_coord(ax), pick_coord(ay));
        else                    queue_point(m, pick_coord('0), pick_coord('0));
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
